[src/rwt_pkg.sv]
`default_nettype none
package rwt_pkg;
    localparam int ADDR_WIDTH_DEF = 32;
    localparam int MAX_RANGES_DEF = 64;
    localparam int IN_ADDR_W      = 32;

    localparam logic [1:0] FUNC_SET   = 2'd0;
    localparam logic [1:0] FUNC_CLEAR = 2'd1;
    localparam logic [1:0] FUNC_CHECK = 2'd2;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_ORDER   = 2'd2;

    localparam logic [1:0] WA_RD      = 2'b01;
    localparam logic [1:0] WA_WR      = 2'b10;
    localparam logic [1:0] WA_ALL     = WA_RD | WA_WR;
endpackage
`default_nettype wire

[src/range_watchpoint_table_core.sv]
// Range watchpoint table. Keeps a sorted, merged partition of the address
// space, each range carrying read (bit 0) and write (bit 1) watch flags.
// Input channel: in_valid / in_stall carries one word of func, first_addr,
// last_addr, flag_bits. func 0 sets flags on the range, 1 clears them,
// 2 checks the range for any requested flag.
// Output channel: out_valid / out_stall returns one word per input word,
// fault and status (0 done, 1 table full, 2 start above end).
// A check walks the stored ranges one by one. An update walks the stored
// ranges to build the new table in a scratch memory, then copies each
// resulting range back into the range memory.
// in_stall is high while a word is being worked on. A finished word sits
// in the output register; a stalled output holds until taken, and the
// next input word is accepted meanwhile.
// Reset returns the table to one range covering everything with no flags.
`default_nettype none
module range_watchpoint_table_core #(
    parameter int ADDR_WIDTH = rwt_pkg::ADDR_WIDTH_DEF,
    parameter int MAX_RANGES = rwt_pkg::MAX_RANGES_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  func,
    input  wire logic [31:0] first_addr,
    input  wire logic [31:0] last_addr,
    input  wire logic [1:0]  flag_bits,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             fault,
    output logic [1:0]       status
);
    localparam int AW       = ADDR_WIDTH;
    localparam int TMP_CAP  = MAX_RANGES + 2;
    localparam int MA       = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
    localparam int TA       = $clog2(TMP_CAP);
    localparam int CW       = $clog2(MAX_RANGES + 1);
    localparam int TCW      = $clog2(TMP_CAP + 1);
    localparam int EW       = AW + rwt_pkg::IN_ADDR_W;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RA   = 4'd1;
    localparam logic [3:0] S_RB   = 4'd2;
    localparam logic [3:0] S_RC   = 4'd3;
    localparam logic [3:0] S_PH   = 4'd4;
    localparam logic [3:0] S_FIN  = 4'd5;
    localparam logic [3:0] S_CR   = 4'd6;
    localparam logic [3:0] S_CW   = 4'd7;
    localparam logic [3:0] S_DONE = 4'd8;

    localparam logic [AW-1:0] ADDR_MAX = {AW{1'b1}};

    logic [AW-1:0] mem_b [MAX_RANGES];
    logic [1:0]    mem_f [MAX_RANGES];
    logic [AW-1:0] tmp_b [TMP_CAP];
    logic [1:0]    tmp_f [TMP_CAP];

    logic [3:0]     state_reg, state_next;
    logic           chk_reg, chk_next;
    logic           set_reg, set_next;
    logic [AW-1:0]  s_reg, s_next, e_reg, e_next;
    logic [1:0]     fl_reg, fl_next;
    logic [CW-1:0]  idx_reg, idx_next;
    logic [AW-1:0]  lo_reg, lo_next, hi_reg, hi_next;
    logic [1:0]     f_reg, f_next;
    logic [1:0]     phase_reg, phase_next;
    logic [TCW-1:0] tcnt_reg, tcnt_next;
    logic [1:0]     lastf_reg, lastf_next;
    logic           over_reg, over_next;
    logic           fault_reg, fault_next;
    logic [1:0]     status_reg, status_next;
    logic [TCW-1:0] cidx_reg, cidx_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           pristine_reg, pristine_next;
    logic           out_valid_reg, out_valid_next;
    logic           out_fault_reg, out_fault_next;
    logic [1:0]     out_status_reg, out_status_next;

    logic [AW-1:0] rd_b_raw, rd_b, tr_b;
    logic [1:0]    rd_f_raw, rd_f, tr_f;
    logic [MA-1:0] rd_addr;
    logic          mem_we, tmp_we;
    logic [CW:0]   idx_inc;
    logic [AW-1:0] s_in, e_in, hi_c, mlo, mhi, p_b;
    logic [1:0]    nf, p_f;
    logic          p_ok, last_rng;
    logic [EW-1:0] s_ext, e_ext;

    assign s_ext = {{AW{1'b0}}, first_addr};
    assign e_ext = {{AW{1'b0}}, last_addr};
    assign s_in  = s_ext[AW-1:0];
    assign e_in  = e_ext[AW-1:0];

    assign idx_inc  = {1'b0, idx_reg} + 1'b1;
    assign last_rng = idx_inc >= {1'b0, count_reg};
    assign rd_addr  = (state_reg == S_RB) ? idx_inc[MA-1:0] : idx_reg[MA-1:0];
    assign rd_b     = pristine_reg ? '0 : rd_b_raw;
    assign rd_f     = pristine_reg ? 2'b00 : rd_f_raw;
    assign hi_c     = last_rng ? ADDR_MAX : rd_b - 1'b1;

    assign nf  = set_reg ? (f_reg | fl_reg) : (f_reg & ~fl_reg);
    assign mlo = (lo_reg > s_reg) ? lo_reg : s_reg;
    assign mhi = (hi_reg < e_reg) ? hi_reg : e_reg;

    always_comb
    begin
        unique case (phase_reg)
            2'd0:
            begin
                p_ok = lo_reg < s_reg;
                p_b  = lo_reg;
                p_f  = f_reg;
            end
            2'd1:
            begin
                p_ok = mlo <= mhi;
                p_b  = mlo;
                p_f  = nf;
            end
            default:
            begin
                p_ok = hi_reg > e_reg;
                p_b  = (lo_reg > e_reg) ? lo_reg : e_reg + 1'b1;
                p_f  = f_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        rd_b_raw <= mem_b[rd_addr];
        rd_f_raw <= mem_f[rd_addr];
        if (mem_we)
        begin
            mem_b[cidx_reg[MA-1:0]] <= tr_b;
            mem_f[cidx_reg[MA-1:0]] <= tr_f;
        end
    end

    always_ff @(posedge clk)
    begin
        tr_b <= tmp_b[cidx_reg[TA-1:0]];
        tr_f <= tmp_f[cidx_reg[TA-1:0]];
        if (tmp_we)
        begin
            tmp_b[tcnt_reg[TA-1:0]] <= p_b;
            tmp_f[tcnt_reg[TA-1:0]] <= p_f;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        chk_next        = chk_reg;
        set_next        = set_reg;
        s_next          = s_reg;
        e_next          = e_reg;
        fl_next         = fl_reg;
        idx_next        = idx_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        f_next          = f_reg;
        phase_next      = phase_reg;
        tcnt_next       = tcnt_reg;
        lastf_next      = lastf_reg;
        over_next       = over_reg;
        fault_next      = fault_reg;
        status_next     = status_reg;
        cidx_next       = cidx_reg;
        count_next      = count_reg;
        pristine_next   = pristine_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_fault_next  = out_fault_reg;
        out_status_next = out_status_reg;
        mem_we          = 1'b0;
        tmp_we          = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    chk_next    = func == rwt_pkg::FUNC_CHECK;
                    set_next    = func == rwt_pkg::FUNC_SET;
                    s_next      = s_in;
                    e_next      = e_in;
                    fl_next     = flag_bits;
                    idx_next    = '0;
                    tcnt_next   = '0;
                    lastf_next  = 2'b00;
                    over_next   = 1'b0;
                    fault_next  = 1'b0;
                    status_next = rwt_pkg::ST_DONE;
                    priority if (func != rwt_pkg::FUNC_SET && func != rwt_pkg::FUNC_CLEAR
                                 && func != rwt_pkg::FUNC_CHECK)
                        state_next = S_DONE;
                    else if (s_in > e_in)
                    begin
                        status_next = rwt_pkg::ST_ORDER;
                        state_next  = S_DONE;
                    end
                    else if (func == rwt_pkg::FUNC_CHECK)
                        state_next = S_RA;
                    else if (flag_bits == 2'b00)
                        state_next = S_DONE;
                    else
                        state_next = S_RA;
                end
            end
            S_RA:
                state_next = S_RB;
            S_RB:
            begin
                lo_next    = rd_b;
                f_next     = rd_f;
                state_next = S_RC;
            end
            S_RC:
            begin
                hi_next    = hi_c;
                phase_next = 2'd0;
                if (chk_reg)
                begin
                    if (lo_reg <= e_reg && hi_c >= s_reg && (f_reg & fl_reg) != 2'b00)
                        fault_next = 1'b1;
                    idx_next   = idx_inc[CW-1:0];
                    state_next = last_rng ? S_DONE : S_RA;
                end
                else
                    state_next = S_PH;
            end
            S_PH:
            begin
                if (p_ok && !(tcnt_reg != '0 && lastf_reg == p_f))
                begin
                    if (tcnt_reg >= TCW'(TMP_CAP))
                        over_next = 1'b1;
                    else
                    begin
                        tmp_we     = 1'b1;
                        tcnt_next  = tcnt_reg + 1'b1;
                        lastf_next = p_f;
                    end
                end
                if (phase_reg == 2'd2)
                begin
                    idx_next   = idx_inc[CW-1:0];
                    state_next = last_rng ? S_FIN : S_RA;
                end
                else
                    phase_next = phase_reg + 1'b1;
            end
            S_FIN:
            begin
                cidx_next = '0;
                if (over_reg || tcnt_reg > TCW'(MAX_RANGES))
                begin
                    status_next = rwt_pkg::ST_FULL;
                    state_next  = S_DONE;
                end
                else
                    state_next = S_CR;
            end
            S_CR:
                state_next = S_CW;
            S_CW:
            begin
                mem_we    = 1'b1;
                cidx_next = cidx_reg + 1'b1;
                if (cidx_reg + 1'b1 == tcnt_reg)
                begin
                    count_next    = tcnt_reg[CW-1:0];
                    pristine_next = 1'b0;
                    state_next    = S_DONE;
                end
                else
                    state_next = S_CR;
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    out_fault_next  = fault_reg;
                    out_status_next = status_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= CW'(1);
            pristine_reg  <= 1'b1;
            out_valid_reg <= 1'b0;
            phase_reg     <= 2'd0;
            tcnt_reg      <= '0;
            idx_reg       <= '0;
            cidx_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pristine_reg  <= pristine_next;
            out_valid_reg <= out_valid_next;
            phase_reg     <= phase_next;
            tcnt_reg      <= tcnt_next;
            idx_reg       <= idx_next;
            cidx_reg      <= cidx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chk_reg        <= chk_next;
        set_reg        <= set_next;
        s_reg          <= s_next;
        e_reg          <= e_next;
        fl_reg         <= fl_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        f_reg          <= f_next;
        lastf_reg      <= lastf_next;
        over_reg       <= over_next;
        fault_reg      <= fault_next;
        status_reg     <= status_next;
        out_fault_reg  <= out_fault_next;
        out_status_reg <= out_status_next;
    end

    assign in_stall  = state_reg != S_IDLE;
    assign out_valid = out_valid_reg;
    assign fault     = out_fault_reg;
    assign status    = out_status_reg;

`ifndef SYNTH
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != '0 && count_reg <= CW'(MAX_RANGES))
        else $error("range count out of bounds");
    a_tcnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
        tcnt_reg <= TCW'(TMP_CAP))
        else $error("scratch count overflow");
    a_phase: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != 2'd3)
        else $error("bad piece phase");
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_status_reg <= rwt_pkg::ST_ORDER
            && !(out_fault_reg && out_status_reg != rwt_pkg::ST_DONE)))
        else $error("bad result word");
    a_copy_ok: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CR |-> (!over_reg && tcnt_reg <= TCW'(MAX_RANGES)))
        else $error("copy of overfull table");
`endif
endmodule
`default_nettype wire
